[src/bpwm_pkg.sv]
// Shared types, constants and the button priority decode for the PWM dimmer.
// No dependencies; every other file in src/ refers to this package by scoped names.
`default_nettype none

package bpwm_pkg;

  localparam int NUM_CHANNELS = 3;
  localparam int CH_W         = $clog2(NUM_CHANNELS + 1);
  localparam int LED_N        = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;

  localparam int BRIGHT_W = 7;
  localparam int PERIOD_W = 10;
  localparam int TICK_W   = 10;
  localparam int PROD_W   = BRIGHT_W + PERIOD_W;

  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT  = 7'd100;
  localparam logic [BRIGHT_W-1:0] BRIGHT_STEP  = 7'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd20;
  localparam logic [PROD_W-1:0]   PCT_SCALE    = 17'd100;

  // button levels, 0 = pressed
  typedef struct packed {
    logic next;
    logic prev;
    logic increase;
    logic decrease;
    logic toggle;
  } btn_t;

  typedef struct packed {
    logic [2:0]          leds;
    logic [1:0]          channel;
    logic [BRIGHT_W-1:0] brightness;
  } result_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_NEXT,
    ACT_PREV,
    ACT_INC,
    ACT_DEC,
    ACT_TOGGLE
  } action_t;

  // first pressed button wins, in order next, prev, increase, decrease, toggle
  function automatic action_t pick_action(btn_t b);
    action_t a;
    if (!b.next) begin
      a = ACT_NEXT;
    end else if (!b.prev) begin
      a = ACT_PREV;
    end else if (!b.increase) begin
      a = ACT_INC;
    end else if (!b.decrease) begin
      a = ACT_DEC;
    end else if (!b.toggle) begin
      a = ACT_TOGGLE;
    end else begin
      a = ACT_NONE;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

[src/bpwm_in_stage.sv]
// Input register for one tick's button levels, with valid/stall handshake.
// Depends on bpwm_pkg.
`default_nettype none

module bpwm_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bpwm_pkg::btn_t btn_in,
  input  wire logic          drain,
  output logic               hold_valid,
  output bpwm_pkg::btn_t     hold_btn
);

  logic take;

  // stage can load when empty or when its transaction moves on this cycle
  assign in_stall = hold_valid && !drain;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_btn <= btn_in;
    end
  end

endmodule

`default_nettype wire

[src/bpwm_ctrl.sv]
// Dimmer state and per-tick update: press lock, channel select, brightness,
// tick counter, period register and PWM drive levels. Depends on bpwm_pkg.
`default_nettype none

module bpwm_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bpwm_pkg::PERIOD_W-1:0]     cfg_wr_data,
  input  wire logic                              fire,
  input  wire bpwm_pkg::btn_t                    btn,
  output bpwm_pkg::result_t                      res
);

  localparam int N = bpwm_pkg::NUM_CHANNELS;

  logic [bpwm_pkg::PERIOD_W-1:0] period;
  logic [bpwm_pkg::TICK_W-1:0]   tick;
  logic [bpwm_pkg::CH_W-1:0]     chosen;
  logic [bpwm_pkg::BRIGHT_W-1:0] bright [N];
  logic                          press_lock;
  logic [N-1:0]                  drive;

  logic [bpwm_pkg::TICK_W-1:0]   tick_next;
  logic [bpwm_pkg::CH_W-1:0]     chosen_next;
  logic [bpwm_pkg::BRIGHT_W-1:0] bright_next [N];
  logic                          lock_next;
  logic [N-1:0]                  drive_next;

  bpwm_pkg::action_t             act;
  logic                          all_released;
  logic                          lock_eff;
  logic [bpwm_pkg::CH_W-1:0]     cur;
  logic [bpwm_pkg::BRIGHT_W-1:0] b_cur;
  logic [bpwm_pkg::BRIGHT_W-1:0] b_new;
  logic [bpwm_pkg::BRIGHT_W:0]   b_sum;
  logic                          b_write;
  logic                          wrap;
  logic [bpwm_pkg::TICK_W:0]     tick_inc;
  logic [bpwm_pkg::PROD_W-1:0]   tick_scaled;
  logic [bpwm_pkg::PROD_W-1:0]   on_scaled [N];
  logic [bpwm_pkg::BRIGHT_W-1:0] out_bright;
  logic [2:0]                    out_leds;

  always_comb begin
    act          = bpwm_pkg::pick_action(btn);
    all_released = &btn;
    lock_eff     = press_lock && !all_released;

    cur = chosen;
    if (chosen == '0 || chosen > bpwm_pkg::CH_W'(N)) begin
      cur = bpwm_pkg::CH_W'(1);
    end

    b_cur = '0;
    for (int i = 0; i < N; i++) begin
      if (cur == bpwm_pkg::CH_W'(i + 1)) begin
        b_cur = b_cur | bright[i];
      end
    end

    b_sum       = {1'b0, b_cur} + {1'b0, bpwm_pkg::BRIGHT_STEP};
    b_new       = b_cur;
    b_write     = 1'b0;
    chosen_next = cur;
    lock_next   = lock_eff;

    if (!lock_eff) begin
      case (act)
        bpwm_pkg::ACT_NEXT: begin
          chosen_next = (cur >= bpwm_pkg::CH_W'(N)) ? bpwm_pkg::CH_W'(1)
                                                     : cur + bpwm_pkg::CH_W'(1);
          lock_next   = 1'b1;
        end
        bpwm_pkg::ACT_PREV: begin
          chosen_next = (cur <= bpwm_pkg::CH_W'(1)) ? bpwm_pkg::CH_W'(N)
                                                     : cur - bpwm_pkg::CH_W'(1);
          lock_next   = 1'b1;
        end
        bpwm_pkg::ACT_INC: begin
          if (b_cur < bpwm_pkg::FULL_BRIGHT) begin
            b_new = (b_sum > {1'b0, bpwm_pkg::FULL_BRIGHT}) ? bpwm_pkg::FULL_BRIGHT
                                                            : b_sum[bpwm_pkg::BRIGHT_W-1:0];
          end
          b_write   = 1'b1;
          lock_next = 1'b1;
        end
        bpwm_pkg::ACT_DEC: begin
          b_new     = (b_cur > bpwm_pkg::BRIGHT_STEP) ? b_cur - bpwm_pkg::BRIGHT_STEP : '0;
          b_write   = 1'b1;
          lock_next = 1'b1;
        end
        bpwm_pkg::ACT_TOGGLE: begin
          b_new     = (b_cur == bpwm_pkg::FULL_BRIGHT) ? '0 : bpwm_pkg::FULL_BRIGHT;
          b_write   = 1'b1;
          lock_next = 1'b1;
        end
        default: begin
        end
      endcase
    end

    for (int i = 0; i < N; i++) begin
      bright_next[i] = (b_write && cur == bpwm_pkg::CH_W'(i + 1)) ? b_new : bright[i];
    end

    // tick < floor(b*period/100)  <=>  100*(tick+1) <= b*period
    wrap        = tick >= period;
    tick_inc    = {1'b0, tick} + {{bpwm_pkg::TICK_W{1'b0}}, 1'b1};
    tick_scaled = bpwm_pkg::PROD_W'(tick_inc) * bpwm_pkg::PCT_SCALE;
    for (int i = 0; i < N; i++) begin
      on_scaled[i]  = bpwm_pkg::PROD_W'(bright_next[i]) * bpwm_pkg::PROD_W'(period);
      drive_next[i] = wrap ? drive[i] : (tick_scaled <= on_scaled[i]);
    end
    tick_next = wrap ? bpwm_pkg::TICK_W'(1) : tick_inc[bpwm_pkg::TICK_W-1:0];

    out_bright = '0;
    for (int i = 0; i < N; i++) begin
      if (chosen_next == bpwm_pkg::CH_W'(i + 1)) begin
        out_bright = out_bright | bright_next[i];
      end
    end
    out_leds = '0;
    for (int i = 0; i < bpwm_pkg::LED_N; i++) begin
      out_leds[i] = drive_next[i];
    end

    res.leds       = out_leds;
    res.channel    = 2'(chosen_next);
    res.brightness = out_bright;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= bpwm_pkg::PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick       <= '0;
      chosen     <= bpwm_pkg::CH_W'(1);
      press_lock <= 1'b0;
      drive      <= '0;
      for (int i = 0; i < N; i++) begin
        bright[i] <= '0;
      end
    end else if (fire) begin
      tick       <= tick_next;
      chosen     <= chosen_next;
      press_lock <= lock_next;
      drive      <= drive_next;
      for (int i = 0; i < N; i++) begin
        bright[i] <= bright_next[i];
      end
    end
  end

endmodule

`default_nettype wire

[src/bpwm_out_stage.sv]
// Result register with valid/stall handshake on the output side.
// Depends on bpwm_pkg.
`default_nettype none

module bpwm_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bpwm_pkg::result_t res_in,
  output logic                   open,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bpwm_pkg::result_t      res_out
);

  // free when empty or when the waiting transaction leaves this cycle
  assign open = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

[src/button_controlled_led_pwm_dimmer.sv]
// Top level of the button-controlled PWM LED dimmer.
// Depends on bpwm_pkg, bpwm_in_stage, bpwm_ctrl and bpwm_out_stage.
//
//   port group   handshake              payload
//   ----------   --------------------   -----------------------------------------------
//   tick in      in_valid / in_stall    btn_next btn_prev btn_increase btn_decrease
//                                       btn_toggle
//   result out   out_valid / out_stall  led_red led_green led_blue selected_channel
//                                       selected_brightness
//   config       cfg_wr_en              cfg_wr_data (period in ticks)
//
// One transaction per cycle sustained while out_stall is low. Each transaction passes
// through the input register, then the update logic into the result register, whose
// load raises out_valid.
// rst is synchronous: period 20, counter 0, channel 1, all brightness and drives 0.
// A stalled result holds the result register; the input register keeps taking one
// more transaction, after which in_stall follows out_stall.
`default_nettype none

module button_controlled_led_pwm_dimmer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpwm_pkg::PERIOD_W-1:0] cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          btn_next,
  input  wire logic                          btn_prev,
  input  wire logic                          btn_increase,
  input  wire logic                          btn_decrease,
  input  wire logic                          btn_toggle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               led_red,
  output logic                               led_green,
  output logic                               led_blue,
  output logic [1:0]                         selected_channel,
  output logic [bpwm_pkg::BRIGHT_W-1:0]      selected_brightness
);

  bpwm_pkg::btn_t    btn_in;
  bpwm_pkg::btn_t    hold_btn;
  bpwm_pkg::result_t res_next;
  bpwm_pkg::result_t res_out;
  logic              hold_valid;
  logic              out_open;
  logic              fire;

  assign btn_in.next     = btn_next;
  assign btn_in.prev     = btn_prev;
  assign btn_in.increase = btn_increase;
  assign btn_in.decrease = btn_decrease;
  assign btn_in.toggle   = btn_toggle;

  assign fire = hold_valid && out_open;

  bpwm_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .btn_in     (btn_in),
    .drain      (out_open),
    .hold_valid (hold_valid),
    .hold_btn   (hold_btn)
  );

  bpwm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .btn         (hold_btn),
    .res         (res_next)
  );

  bpwm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_next),
    .open      (out_open),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign led_red             = res_out.leds[0];
  assign led_green           = res_out.leds[1];
  assign led_blue            = res_out.leds[2];
  assign selected_channel    = res_out.channel;
  assign selected_brightness = res_out.brightness;

endmodule

`default_nettype wire
